// ===== rtl/bscd_pkg.sv =====
// ----------------------------------------------------------------------------
// bscd_pkg
// Shared widths, constants and types for the bike speed/cadence decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bscd_pkg;

    localparam int VAL_W      = 16;
    localparam int CIRC_W     = 12;
    localparam int DIST_W     = 40;
    localparam int QUOT_W     = 16;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_NUM_W  = 42;
    localparam int DIV_DEN_W  = 23;
    localparam int DIV_DS_W   = DIV_DEN_W + DIV_STEPS - 1;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int PROD_W     = VAL_W + CIRC_W;
    localparam int MUL_CNT_W  = $clog2(CIRC_W + 1);
    localparam int IN_W       = 8 * VAL_W / 2;
    localparam int OUT_W      = 2 * QUOT_W + DIST_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [CIRC_W-1:0]  DEFAULT_CIRC = CIRC_W'(2096);
    localparam logic [APB_AW-1:0]  REG_CIRC     = APB_AW'(0);
    localparam logic [QUOT_W-1:0]  QUOT_SAT     = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX     = '1;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

endpackage : bscd_pkg

`default_nettype wire

// ===== rtl/bscd_div.sv =====
// ----------------------------------------------------------------------------
// bscd_div
// Radix-2 restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bscd_div
    import bscd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output div_res_t                  res
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] r_reg, r_next;
    logic [DIV_DS_W-1:0]  ds_reg, ds_next;
    logic [QUOT_W-1:0]    q_reg, q_next;
    logic                 sat;
    logic                 ge;

    assign sat = num >= DIV_NUM_W'({den, {DIV_STEPS{1'b0}}});
    assign ge  = r_reg >= DIV_NUM_W'(ds_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        ds_next   = ds_reg;
        q_next    = q_reg;
        if (start)
        begin
            r_next  = num;
            ds_next = {den, {(DIV_STEPS-1){1'b0}}};
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            if (sat)
            begin
                q_next    = QUOT_SAT;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                q_next    = '0;
                busy_next = 1'b1;
                done_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                r_next = r_reg - DIV_NUM_W'(ds_reg);
            end
            q_next   = {q_reg[QUOT_W-2:0], ge};
            ds_next  = ds_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        ds_reg <= ds_next;
        q_reg  <= q_next;
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.quot = q_reg;

`ifndef SYNTHESIS
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with zero step count");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
    a_sat_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && sat) |=> (done_reg && q_reg == QUOT_SAT))
        else $error("saturated quotient not delivered");
`endif

endmodule : bscd_div

`default_nettype wire

// ===== rtl/bike_speed_cadence_decoder_core.sv =====
// ----------------------------------------------------------------------------
// bike_speed_cadence_decoder_core
// Decodes combined speed/cadence sensor pages into cadence, speed, distance.
// ----------------------------------------------------------------------------
//  channel   signals                         payload
//  s_axis    tvalid/tready/tdata[63:0]       8 page bytes
//  m_axis    tvalid/tready/tdata[71:0]/tuser cadence, speed, distance, flags
//  apb       psel/penable/pwrite/paddr/...   wheel circumference at 0x0
//
//  Unchanged page: no item. Changed page: delta, 12-step serial multiply,
//  divider start, two 16-step dividers side by side, load; the next page is
//  accepted only after the load.
//  Input is taken only when the sequencer is idle; a pending output item
//  does not block input, only the final load waits on m_axis_tready.
//  Reset: sequencer idle, history, held values and distance zero, circumference 2096.
// ----------------------------------------------------------------------------
`default_nettype none

module bike_speed_cadence_decoder_core
    import bscd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // ct_lo, ct_hi, cc_lo, cc_hi, wt_lo, wt_hi, wc_lo, wc_hi (byte each)
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // cadence_rpm[15:0], speed_centi_kmh[31:16], total_distance_mm[71:32]
    output logic [OUT_W-1:0]       m_axis_tdata,
    // crank_changed[0], wheel_changed[1]
    output logic [1:0]             m_axis_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DELTA = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIVS  = 3'd3;
    localparam logic [2:0] ST_DIVW  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CIRC_W-1:0]    circ_reg, circ_next;
    logic [IN_W-1:0]      page_reg, page_next;
    logic [VAL_W-1:0]     last_ct_reg, last_ct_next;
    logic [VAL_W-1:0]     last_cc_reg, last_cc_next;
    logic [VAL_W-1:0]     last_wt_reg, last_wt_next;
    logic [VAL_W-1:0]     last_wc_reg, last_wc_next;
    logic [QUOT_W-1:0]    held_cad_reg, held_cad_next;
    logic [QUOT_W-1:0]    held_spd_reg, held_spd_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic [VAL_W-1:0]     dct_reg, dct_next;
    logic [VAL_W-1:0]     dcc_reg, dcc_next;
    logic [VAL_W-1:0]     dwt_reg, dwt_next;
    logic                 crank_chg_reg, crank_chg_next;
    logic                 wheel_chg_reg, wheel_chg_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [PROD_W-1:0]    mcand_reg, mcand_next;
    logic [CIRC_W-1:0]    mplier_reg, mplier_next;
    logic [MUL_CNT_W-1:0] mcnt_reg, mcnt_next;
    logic                 mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]     mdata_reg, mdata_next;
    logic [1:0]           muser_reg, muser_next;

    logic [VAL_W-1:0]     ct, cc, wt, wc;
    logic [VAL_W-1:0]     dwc;
    logic                 crank_chg, wheel_chg;
    logic [CIRC_W-1:0]    circ_eff;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] num_cad, num_spd;
    logic [DIV_DEN_W-1:0] den_cad, den_spd;
    div_res_t             res_cad, res_spd;
    logic [DIST_W:0]      dist_sum;
    logic [QUOT_W-1:0]    cad_new, spd_new;
    logic [DIST_W-1:0]    dist_new;
    logic                 out_free;
    logic                 load_out;
    logic                 cfg_wr;

    assign ct = page_reg[15:0];
    assign cc = page_reg[31:16];
    assign wt = page_reg[47:32];
    assign wc = page_reg[63:48];

    assign dwc       = wc - last_wc_reg;
    assign crank_chg = (ct != last_ct_reg) || (cc != last_cc_reg);
    assign wheel_chg = (wt != last_wt_reg) || (wc != last_wc_reg);
    assign circ_eff  = (circ_reg != '0) ? circ_reg : DEFAULT_CIRC;

    // cadence: dcc*61440/dct, speed: prod*36864/(dwt*100) == prod*9216/(dwt*25)
    assign num_cad = DIV_NUM_W'({dcc_reg, 16'b0}) - DIV_NUM_W'({dcc_reg, 12'b0});
    assign den_cad = DIV_DEN_W'(dct_reg);
    assign num_spd = DIV_NUM_W'({prod_reg, 13'b0}) + DIV_NUM_W'({prod_reg, 10'b0});
    assign den_spd = DIV_DEN_W'({dwt_reg, 4'b0}) + DIV_DEN_W'({dwt_reg, 3'b0})
                   + DIV_DEN_W'(dwt_reg);
    assign div_start = (state_reg == ST_DIVS);

    bscd_div u_div_cad (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_cad),
        .den   (den_cad),
        .res   (res_cad)
    );

    bscd_div u_div_spd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_spd),
        .den   (den_spd),
        .res   (res_spd)
    );

    assign dist_sum = {1'b0, dist_reg} + (DIST_W+1)'(prod_reg);
    assign dist_new = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
    assign cad_new  = (dct_reg != '0) ? res_cad.quot : held_cad_reg;
    assign spd_new  = (dwt_reg != '0) ? res_spd.quot : held_spd_reg;

    assign out_free = !mvalid_reg || m_axis_tready;
    assign load_out = (state_reg == ST_DIVW) && res_cad.done && res_spd.done && out_free;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb
    begin
        state_next     = state_reg;
        circ_next      = circ_reg;
        page_next      = page_reg;
        last_ct_next   = last_ct_reg;
        last_cc_next   = last_cc_reg;
        last_wt_next   = last_wt_reg;
        last_wc_next   = last_wc_reg;
        held_cad_next  = held_cad_reg;
        held_spd_next  = held_spd_reg;
        dist_next      = dist_reg;
        dct_next       = dct_reg;
        dcc_next       = dcc_reg;
        dwt_next       = dwt_reg;
        crank_chg_next = crank_chg_reg;
        wheel_chg_next = wheel_chg_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mcnt_next      = mcnt_reg;
        mvalid_next    = mvalid_reg;
        mdata_next     = mdata_reg;
        muser_next     = muser_reg;

        if (cfg_wr && (paddr[APB_AW-1:2] == REG_CIRC[APB_AW-1:2]))
        begin
            circ_next = pwdata[CIRC_W-1:0];
        end

        if (mvalid_reg && m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    page_next  = s_axis_tdata;
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                crank_chg_next = crank_chg;
                wheel_chg_next = wheel_chg;
                dct_next    = ct - last_ct_reg;
                dcc_next    = cc - last_cc_reg;
                dwt_next    = wt - last_wt_reg;
                mcand_next  = PROD_W'(dwc);
                mplier_next = circ_eff;
                prod_next   = '0;
                mcnt_next   = MUL_CNT_W'(CIRC_W);
                state_next  = (crank_chg || wheel_chg) ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                mcnt_next   = mcnt_reg - 1'b1;
                if (mcnt_reg == MUL_CNT_W'(1))
                begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (load_out)
                begin
                    held_cad_next = cad_new;
                    held_spd_next = spd_new;
                    dist_next     = dist_new;
                    last_ct_next  = ct;
                    last_cc_next  = cc;
                    last_wt_next  = wt;
                    last_wc_next  = wc;
                    mvalid_next   = 1'b1;
                    mdata_next    = {dist_new, spd_new, cad_new};
                    muser_next    = {wheel_chg_reg, crank_chg_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            circ_reg     <= DEFAULT_CIRC;
            last_ct_reg  <= '0;
            last_cc_reg  <= '0;
            last_wt_reg  <= '0;
            last_wc_reg  <= '0;
            held_cad_reg <= '0;
            held_spd_reg <= '0;
            dist_reg     <= '0;
            mcnt_reg     <= '0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            circ_reg     <= circ_next;
            last_ct_reg  <= last_ct_next;
            last_cc_reg  <= last_cc_next;
            last_wt_reg  <= last_wt_next;
            last_wc_reg  <= last_wc_next;
            held_cad_reg <= held_cad_next;
            held_spd_reg <= held_spd_next;
            dist_reg     <= dist_next;
            mcnt_reg     <= mcnt_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        dct_reg       <= dct_next;
        dcc_reg       <= dcc_next;
        dwt_reg       <= dwt_next;
        crank_chg_reg <= crank_chg_next;
        wheel_chg_reg <= wheel_chg_next;
        prod_reg      <= prod_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        mdata_reg     <= mdata_next;
        muser_reg     <= muser_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[APB_AW-1:2] == REG_CIRC[APB_AW-1:2])
                         ? APB_DW'(circ_reg) : '0;

`ifndef SYNTHESIS
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_axis_tvalid)
        else $error("result load did not raise output valid");
    a_dist_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (dist_reg >= $past(dist_reg)))
        else $error("distance decreased");
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!res_cad.busy && !res_spd.busy))
        else $error("divider busy while idle");
    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (mcnt_reg != '0))
        else $error("multiplier running with zero count");
`endif

endmodule : bike_speed_cadence_decoder_core

`default_nettype wire

// ===== bench/bike_speed_cadence_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// bike_speed_cadence_decoder_core_tb
// Drives sensor pages into the decoder and checks every output item against
// an in-bench model of cadence, speed and distance. Pages come from directed
// edge cases, then mostly plausible rides mixed with repeats, stalled timers,
// bursts and noise. The wheel circumference is changed between phases, and a
// final run at full wheel delta drives the largest distance steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bike_speed_cadence_decoder_core_tb;

    import bscd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT      = 16;
    localparam int FULL_RUN      = 40;

    typedef struct packed {
        logic [15:0] wheel_count;
        logic [15:0] wheel_time;
        logic [15:0] crank_count;
        logic [15:0] crank_time;
    } page_t;

    typedef struct {
        logic [15:0] cadence;
        logic [15:0] speed;
        logic [39:0] distance;
        logic        crank_moved;
        logic        wheel_moved;
    } reading_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // crank_time[15:0], crank_count[31:16], wheel_time[47:32], wheel_count[63:48]
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // cadence_rpm[15:0], speed_centi_kmh[31:16], total_distance_mm[71:32]
    logic [OUT_W-1:0]  m_axis_tdata;
    // crank_changed[0], wheel_changed[1]
    logic [1:0]        m_axis_tuser;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bike_speed_cadence_decoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // pages waiting to be sent, readings waiting to come out
    page_t       page_q[$];
    reading_t    reading_q[$];
    page_t       last_pg      = '0;
    int          pages_pushed = 0;
    int          pages_taken  = 0;
    int          err_cnt      = 0;
    int          idle_cycles  = 0;
    bit          no_idle      = 1'b0;
    bit          in_taken     = 1'b0;

    // model state
    logic [11:0] circ_reg     = DEFAULT_CIRC;
    page_t       prev_pg      = '0;
    logic [15:0] cadence_hold = '0;
    logic [15:0] speed_hold   = '0;
    logic [39:0] dist_acc     = '0;

    function automatic logic [15:0] sat16(input logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit decode_page(input page_t pg, output reading_t rd);
        logic [15:0] dct, dcc, dwt, dwc;
        logic [63:0] circ_eff, add, sum;
        bit          crank_moved, wheel_moved;
        crank_moved = (pg.crank_time != prev_pg.crank_time) ||
                      (pg.crank_count != prev_pg.crank_count);
        wheel_moved = (pg.wheel_time != prev_pg.wheel_time) ||
                      (pg.wheel_count != prev_pg.wheel_count);
        if (!crank_moved && !wheel_moved)
            return 1'b0;
        dct = pg.crank_time - prev_pg.crank_time;
        dcc = pg.crank_count - prev_pg.crank_count;
        dwt = pg.wheel_time - prev_pg.wheel_time;
        dwc = pg.wheel_count - prev_pg.wheel_count;
        if (dct != 0)
            cadence_hold = sat16(64'(dcc) * 64'd61440 / 64'(dct));
        circ_eff = (circ_reg == 0) ? 64'(DEFAULT_CIRC) : 64'(circ_reg);
        add = 64'(dwc) * circ_eff;
        if (dwt != 0)
            speed_hold = sat16(add * 64'd36864 / (64'(dwt) * 64'd100));
        sum = 64'(dist_acc) + add;
        dist_acc = (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[39:0];
        prev_pg = pg;
        rd.cadence     = cadence_hold;
        rd.speed       = speed_hold;
        rd.distance    = dist_acc;
        rd.crank_moved = crank_moved;
        rd.wheel_moved = wheel_moved;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (page_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_axis_tdata  <= page_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor and model, sampled on the rising edge
    always @(posedge clk)
    begin
        reading_t want, fresh;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reading_q.size() == 0)
                begin
                    err_cnt++;
                    $error("output item with no reading expected");
                end
                else
                begin
                    want = reading_q.pop_front();
                    check_field("cadence_rpm", 64'(want.cadence), 64'(m_axis_tdata[15:0]));
                    check_field("speed_centi_kmh", 64'(want.speed),
                                64'(m_axis_tdata[31:16]));
                    check_field("total_distance_mm", 64'(want.distance),
                                64'(m_axis_tdata[71:32]));
                    check_field("crank_changed", 64'(want.crank_moved),
                                64'(m_axis_tuser[0]));
                    check_field("wheel_changed", 64'(want.wheel_moved),
                                64'(m_axis_tuser[1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pages_taken++;
                if (decode_page(page_t'(s_axis_tdata), fresh))
                    reading_q.push_back(fresh);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_page(input logic [15:0] ct, input logic [15:0] cc,
                             input logic [15:0] wt, input logic [15:0] wc);
        last_pg = '{wheel_count: wc, wheel_time: wt, crank_count: cc, crank_time: ct};
        page_q.push_back(last_pg);
        pages_pushed++;
    endtask

    task automatic push_random(input int n);
        page_t np;
        int    pick;
        for (int i = 0; i < n; i++)
        begin
            np   = last_pg;
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // plausible ride
                if ($urandom_range(3) != 0)
                begin
                    np.crank_time  += 16'($urandom_range(1, 3000));
                    np.crank_count += 16'($urandom_range(0, 3));
                end
                if ($urandom_range(3) != 0)
                begin
                    np.wheel_time  += 16'($urandom_range(1, 3000));
                    np.wheel_count += 16'($urandom_range(0, 6));
                end
            end
            else if (pick < 70)
            begin
                np = last_pg;
            end
            else if (pick < 80)
            begin
                // count moves, timer stuck
                if ($urandom_range(1) != 0)
                    np.crank_count += 16'($urandom_range(1, 65535));
                else
                    np.wheel_count += 16'($urandom_range(1, 65535));
            end
            else if (pick < 90)
            begin
                // short time, big count: saturating rates
                np.crank_time  += 16'($urandom_range(1, 4));
                np.crank_count += 16'($urandom_range(0, 65535));
                np.wheel_time  += 16'($urandom_range(1, 4));
                np.wheel_count += 16'($urandom_range(0, 65535));
            end
            else
            begin
                np = page_t'({$urandom(), $urandom()});
            end
            push_page(np.crank_time, np.crank_count, np.wheel_time, np.wheel_count);
        end
    endtask

    task automatic wait_drained();
        while (pages_taken != pages_pushed || reading_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_CIRC;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read back the current setting, then write a new one
    task automatic set_circ(input logic [11:0] value);
        logic [31:0] rd;
        wait_drained();
        apb_xfer(1'b0, '0, rd);
        check_field("wheel_circumference_mm", 64'(circ_reg), 64'(rd));
        apb_xfer(1'b1, {20'($urandom()), value}, rd);
        circ_reg = value;
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset circumference
        push_page(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // same as reset: no item
        push_page(16'd1024, 16'd1, 16'h0000, 16'h0000);     // crank only
        push_page(16'd1024, 16'd1, 16'd1024, 16'd1);        // wheel only
        push_page(16'd1024, 16'd1, 16'd1024, 16'd1);        // repeat
        push_page(16'd1024, 16'd5, 16'd2048, 16'd2);        // crank time stuck
        push_page(16'd2048, 16'd6, 16'd2048, 16'd4);        // wheel time stuck
        push_page(16'd2049, 16'd60006, 16'd2048, 16'd4);    // cadence saturates
        push_page(16'd2049, 16'd60006, 16'd2049, 16'd1004); // speed saturates
        push_page(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_page(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // all deltas wrap to 1
        push_page(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // all deltas 0xFFFF
        push_page(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
        push_page(16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF);
        push_page(16'hFF10, 16'h00FF, 16'hFF00, 16'h00FF);  // crank time only
        push_page(16'hFF10, 16'h00FF, 16'hFF20, 16'h00FF);  // wheel time only

        // zero circumference falls back to the default
        set_circ(12'd0);
        push_page(16'h0310, 16'h0100, 16'h0320, 16'h0100);
        push_page(16'h0710, 16'h0103, 16'h0720, 16'h0105);
        push_page(16'h0710, 16'h0103, 16'h0720, 16'h0105);

        set_circ(12'd1);
        push_page(16'h0B10, 16'h0104, 16'h0B20, 16'h0106);
        push_random(250);

        set_circ(12'd4095);
        no_idle = 1'b1;
        push_random(250);
        wait_drained();
        no_idle = 1'b0;

        for (int k = 0; k < 3; k++)
        begin
            set_circ(12'($urandom_range(1, 4095)));
            push_random(170);
        end

        // full wheel delta at max circumference: largest distance steps
        set_circ(12'd4095);
        for (int i = 0; i < FULL_RUN; i++)
            push_page(last_pg.crank_time + 16'($urandom_range(1, 3000)),
                      last_pg.crank_count + 16'($urandom_range(0, 3)),
                      last_pg.wheel_time + 16'($urandom_range(1, 65535)),
                      last_pg.wheel_count - 16'd1);
        push_random(30);

        wait_drained();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
